// ----- hw/rtl/oasf_pkg.sv -----
// ----------------------------------------------------------------------------
// Offer/answer session FSM package
// Shared codes, the result record and the message builder used by the
// session controller.
// ----------------------------------------------------------------------------
`default_nettype none

package oasf_pkg;

   localparam int ID_BITS = 64;
   localparam int SEQ_BITS = 32;
   localparam logic [63:0] ID_MASK = {64{1'b1}} >> (64 - ID_BITS);

   typedef enum logic [1:0] {
      CMD_RECV  = 2'd0,
      CMD_OFFER = 2'd1,
      CMD_CLOSE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      MT_INVALID  = 3'd0,
      MT_OFFER    = 3'd1,
      MT_ANSWER   = 3'd2,
      MT_OK       = 3'd3,
      MT_ERROR    = 3'd4,
      MT_SHUTDOWN = 3'd5
   } msg_kind_type;

   typedef enum logic [2:0] {
      ER_NONE           = 3'd0,
      ER_NOMATCH        = 3'd1,
      ER_TIMEOUT        = 3'd2,
      ER_REFUSED        = 3'd3,
      ER_CONFLICT       = 3'd4,
      ER_DOUBLECONFLICT = 3'd5,
      ER_FAILED         = 3'd6
   } err_kind_type;

   typedef enum logic [2:0] {
      ST_START          = 3'd0,
      ST_WAIT_ANSWER    = 3'd1,
      ST_WAIT_COMPLETED = 3'd2,
      ST_COMPLETED      = 3'd3,
      ST_WAIT_SHUTDOWN  = 3'd4,
      ST_CLOSED         = 3'd5
   } state_type;

   typedef struct packed {
      logic                send_valid;
      logic [2:0]          out_type;
      logic [2:0]          out_error;
      logic [SEQ_BITS-1:0] out_seq;
      logic [63:0]         out_offerer_id;
      logic                out_offerer_present;
      logic [63:0]         out_answerer_id;
      logic                out_answerer_present;
      logic                closed_event;
      logic                remote_desc_event;
      logic [2:0]          session_state_now;
   } rsp_type;

   // Builds a result carrying one outgoing message; events and state are
   // filled in by the caller.
   function automatic rsp_type put_msg(
      input msg_kind_type        kind,
      input err_kind_type        err,
      input logic [SEQ_BITS-1:0] seq,
      input logic [63:0]         oid,
      input logic                opres,
      input logic [63:0]         aid,
      input logic                apres
   );
      rsp_type r;
      r = '0;
      r.send_valid           = 1'b1;
      r.out_type             = kind;
      r.out_error            = err;
      r.out_seq              = seq;
      r.out_offerer_id       = oid & ID_MASK;
      r.out_offerer_present  = opres;
      r.out_answerer_id      = aid & ID_MASK;
      r.out_answerer_present = apres;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/oasf_if.sv -----
// ----------------------------------------------------------------------------
// Offer/answer session FSM channel interfaces
// Valid/ready channels for request beats, response beats and the
// session id register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface oasf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [2:0]  msg_type;
   logic [2:0]  err_type;
   logic [31:0] msg_seq;
   logic [63:0] offerer_id;
   logic        offerer_present;
   logic [63:0] answerer_id;
   logic        answerer_present;

   modport source (
      output valid, cmd, msg_type, err_type, msg_seq, offerer_id,
             offerer_present, answerer_id, answerer_present,
      input  ready
   );
   modport sink (
      input  valid, cmd, msg_type, err_type, msg_seq, offerer_id,
             offerer_present, answerer_id, answerer_present,
      output ready
   );
endinterface

interface oasf_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic [2:0]  out_type;
   logic [2:0]  out_error;
   logic [31:0] out_seq;
   logic [63:0] out_offerer_id;
   logic        out_offerer_present;
   logic [63:0] out_answerer_id;
   logic        out_answerer_present;
   logic        closed_event;
   logic        remote_desc_event;
   logic [2:0]  session_state_now;

   modport source (
      output valid, send_valid, out_type, out_error, out_seq, out_offerer_id,
             out_offerer_present, out_answerer_id, out_answerer_present,
             closed_event, remote_desc_event, session_state_now,
      input  ready
   );
   modport sink (
      input  valid, send_valid, out_type, out_error, out_seq, out_offerer_id,
             out_offerer_present, out_answerer_id, out_answerer_present,
             closed_event, remote_desc_event, session_state_now,
      output ready
   );
endinterface

interface oasf_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/offer_answer_session_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// Offer/answer session FSM unit
// Offerer side of an offer/answer session: session state, sequence number
// and learned peer id, driven by offer, close and received-message beats.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one response beat. The unit takes one
// request beat per clock cycle when the response side keeps up: a beat is
// captured in the input register, evaluated against the session state and
// written into the response register, from which the response is
// presented. The session state, sequence number and peer id are updated in
// the same cycle the response register is loaded, so back-to-back requests
// see the effect of the one before them. When the response register is held
// by a stalled consumer, the input register still takes one more beat before
// ready drops. The session id register is written through the csr channel,
// which is always ready; write it only while no request is in flight.
`default_nettype none

module offer_answer_session_fsm_unit
   import oasf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   oasf_req_if.sink    req_bus,
   oasf_rsp_if.source  rsp_bus,
   oasf_csr_if.sink    csr_bus
);

   // Input register stage.
   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_cmd_ff;
   logic [2:0]          s1_msg_type_ff;
   logic [SEQ_BITS-1:0] s1_seq_ff;
   logic [63:0]         s1_oid_ff;
   logic                s1_opres_ff;
   logic [63:0]         s1_aid_ff;
   logic                s1_apres_ff;

   // Response register stage.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Session state.
   state_type           state_ff, state_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [63:0]         peer_id_ff, peer_id_in;
   logic                peer_known_ff, peer_known_in;
   logic [63:0]         my_id_ff;

   logic req_fire;
   logic s1_advance;
   logic seq_bad;
   logic peer_bad;
   cmd_type      cmd;
   msg_kind_type mt;

   // The response register can take a new beat when it is empty or being
   // drained this cycle; the input register follows it.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign cmd = cmd_type'(s1_cmd_ff);
   assign mt  = msg_kind_type'(s1_msg_type_ff);

   // A received message is rejected first on a sequence mismatch, then on
   // a peer id mismatch once the peer is known.
   assign seq_bad  = (s1_seq_ff != seq_ff);
   assign peer_bad = peer_known_ff && !(s1_apres_ff && (s1_aid_ff == peer_id_ff));

   // Next-state logic for the session.
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      peer_id_in    = peer_id_ff;
      peer_known_in = peer_known_ff;
      case (cmd)
         CMD_OFFER: begin
            state_in = ST_WAIT_ANSWER;
         end
         CMD_CLOSE: begin
            if (state_ff != ST_CLOSED) begin
               state_in = ST_WAIT_SHUTDOWN;
            end
         end
         CMD_RECV: begin
            if (seq_bad || peer_bad) begin
               state_in = ST_CLOSED;
            end else begin
               case (state_ff)
                  ST_START: begin
                     if (mt == MT_SHUTDOWN) begin
                        state_in = ST_CLOSED;
                     end
                  end
                  ST_WAIT_ANSWER: begin
                     if (mt == MT_ANSWER) begin
                        if (!peer_known_ff && s1_apres_ff) begin
                           peer_id_in    = s1_aid_ff;
                           peer_known_in = 1'b1;
                        end
                        state_in = ST_COMPLETED;
                        seq_in   = seq_ff + 1'b1;
                     end else if (mt == MT_ERROR || mt == MT_SHUTDOWN) begin
                        state_in = ST_CLOSED;
                     end
                  end
                  ST_WAIT_COMPLETED: begin
                     if (mt == MT_OK) begin
                        seq_in   = seq_ff + 1'b1;
                        state_in = ST_COMPLETED;
                     end else if (mt == MT_SHUTDOWN) begin
                        state_in = ST_CLOSED;
                     end
                  end
                  ST_WAIT_SHUTDOWN: begin
                     if (mt == MT_OK || mt == MT_SHUTDOWN) begin
                        state_in = ST_CLOSED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Output logic: the outgoing message and events for the current beat.
   always_comb begin
      rsp_in = '0;
      case (cmd)
         CMD_OFFER: begin
            rsp_in = put_msg(MT_OFFER, ER_NONE, seq_ff, my_id_ff, 1'b1, 64'd0, 1'b0);
         end
         CMD_CLOSE: begin
            if (state_ff != ST_CLOSED) begin
               rsp_in = put_msg(MT_SHUTDOWN, ER_NONE, seq_ff, my_id_ff, 1'b1,
                                peer_known_ff ? peer_id_ff : 64'd0, peer_known_ff);
            end
         end
         CMD_RECV: begin
            if (seq_bad) begin
               rsp_in = put_msg(MT_ERROR, ER_FAILED, s1_seq_ff, s1_oid_ff, s1_opres_ff,
                                s1_aid_ff, s1_apres_ff);
               rsp_in.closed_event = 1'b1;
            end else if (peer_bad) begin
               rsp_in = put_msg(MT_ERROR, ER_NOMATCH, seq_ff, s1_oid_ff, s1_opres_ff,
                                s1_aid_ff, s1_apres_ff);
               rsp_in.closed_event = 1'b1;
            end else begin
               case (state_ff)
                  ST_START, ST_WAIT_COMPLETED: begin
                     if (mt == MT_SHUTDOWN) begin
                        rsp_in = put_msg(MT_OK, ER_NONE, s1_seq_ff, s1_oid_ff,
                                         s1_opres_ff, s1_aid_ff, s1_apres_ff);
                        rsp_in.closed_event = 1'b1;
                     end
                  end
                  ST_WAIT_ANSWER: begin
                     if (mt == MT_ANSWER) begin
                        rsp_in = put_msg(MT_OK, ER_NONE, seq_ff, s1_oid_ff,
                                         s1_opres_ff, s1_aid_ff, s1_apres_ff);
                        rsp_in.remote_desc_event = 1'b1;
                     end else if (mt == MT_SHUTDOWN) begin
                        // Closing from wait answer sends no close notification.
                        rsp_in = put_msg(MT_OK, ER_NONE, s1_seq_ff, s1_oid_ff,
                                         s1_opres_ff, s1_aid_ff, s1_apres_ff);
                     end
                  end
                  ST_WAIT_SHUTDOWN: begin
                     if (mt == MT_OK) begin
                        rsp_in.closed_event = 1'b1;
                     end else if (mt == MT_SHUTDOWN) begin
                        rsp_in = put_msg(MT_OK, ER_NONE, s1_seq_ff, s1_oid_ff,
                                         s1_opres_ff, s1_aid_ff, s1_apres_ff);
                        rsp_in.closed_event = 1'b1;
                     end else begin
                        // Anything else repeats the shutdown request.
                        rsp_in = put_msg(MT_SHUTDOWN, ER_NONE, s1_seq_ff, s1_oid_ff,
                                         s1_opres_ff, s1_aid_ff, s1_apres_ff);
                     end
                  end
                  ST_CLOSED: begin
                     rsp_in = put_msg(MT_ERROR, ER_NOMATCH, seq_ff, s1_oid_ff,
                                      s1_opres_ff, s1_aid_ff, s1_apres_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      rsp_in.session_state_now = state_in;
   end

   // Stage valid bits.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= ST_START;
         seq_ff        <= SEQ_BITS'(1);
         peer_id_ff    <= '0;
         peer_known_ff <= 1'b0;
         my_id_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff      <= state_in;
            seq_ff        <= seq_in;
            peer_id_ff    <= peer_id_in;
            peer_known_ff <= peer_known_in;
         end
         if (csr_bus.valid) begin
            my_id_ff <= csr_bus.data & ID_MASK;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff      <= req_bus.cmd;
         s1_msg_type_ff <= req_bus.msg_type;
         s1_seq_ff      <= req_bus.msg_seq;
         s1_oid_ff      <= req_bus.offerer_id & ID_MASK;
         s1_opres_ff    <= req_bus.offerer_present;
         s1_aid_ff      <= req_bus.answerer_id & ID_MASK;
         s1_apres_ff    <= req_bus.answerer_present;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // The error type of a received message has no effect on the session.
   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.send_valid           = rsp_ff.send_valid;
   assign rsp_bus.out_type             = rsp_ff.out_type;
   assign rsp_bus.out_error            = rsp_ff.out_error;
   assign rsp_bus.out_seq              = rsp_ff.out_seq;
   assign rsp_bus.out_offerer_id       = rsp_ff.out_offerer_id;
   assign rsp_bus.out_offerer_present  = rsp_ff.out_offerer_present;
   assign rsp_bus.out_answerer_id      = rsp_ff.out_answerer_id;
   assign rsp_bus.out_answerer_present = rsp_ff.out_answerer_present;
   assign rsp_bus.closed_event         = rsp_ff.closed_event;
   assign rsp_bus.remote_desc_event    = rsp_ff.remote_desc_event;
   assign rsp_bus.session_state_now    = rsp_ff.session_state_now;

endmodule

`default_nettype wire
